// ===== sv/round_robin_run_queue_assert.svh =====
// Assertion macros for the run queue.
`ifndef ROUND_ROBIN_RUN_QUEUE_ASSERT_SVH
`define ROUND_ROBIN_RUN_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RRQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rrq_pkg.sv =====
// Shared types and defaults for the run queue.
`default_nettype none

package rrq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF     = 64;
    localparam int unsigned THREAD_ID_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_YIELD   = 2'd1,
        OP_POP     = 2'd2,
        OP_SWITCH  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ===== sv/rrq_req_if.sv =====
// Request channel of the run queue.
`default_nettype none

interface rrq_req_if #(
    parameter int unsigned ID_W = rrq_pkg::THREAD_ID_WIDTH_DEF
);
    import rrq_pkg::*;

    logic            valid;
    logic            ready;
    op_t             op;
    logic [ID_W-1:0] thread_id;
    logic            target_terminated;

    modport source (output valid, op, thread_id, target_terminated, input ready);
    modport sink   (input valid, op, thread_id, target_terminated, output ready);
endinterface

`default_nettype wire

// ===== sv/rrq_rsp_if.sv =====
// Result channel of the run queue.
`default_nettype none

interface rrq_rsp_if #(
    parameter int unsigned ID_W  = rrq_pkg::THREAD_ID_WIDTH_DEF,
    parameter int unsigned CNT_W = $clog2(rrq_pkg::QUEUE_DEPTH_DEF + 1)
);
    import rrq_pkg::*;

    logic             valid;
    logic             ready;
    logic [ID_W-1:0]  popped_thread;
    logic             popped_valid;
    logic [ID_W-1:0]  current_thread;
    logic             current_valid;
    status_t          status;
    logic [CNT_W-1:0] queue_count;

    modport source (output valid, popped_thread, popped_valid, current_thread,
                    current_valid, status, queue_count, input ready);
    modport sink   (input valid, popped_thread, popped_valid, current_thread,
                    current_valid, status, queue_count, output ready);
endinterface

`default_nettype wire

// ===== sv/rrq_ram.sv =====
// Generic single-clock RAM, one write port, one registered read port.
`default_nettype none

module rrq_ram #(
    parameter int unsigned WIDTH = rrq_pkg::THREAD_ID_WIDTH_DEF,
    parameter int unsigned DEPTH = rrq_pkg::QUEUE_DEPTH_DEF,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

// ===== sv/round_robin_run_queue.sv =====
// Flow: enqueue, switch and empty-queue requests go from idle straight to the done state;
// yield with a current thread passes through the read state; pop (and yield with none current)
// reads, then takes a shift step per entry above the cursor, the tail moving down one entry per cycle.
// One request at a time: the next is taken once the result is in the output register.
// Reset clears count, cursor, current thread and handshake state; the entry RAM is not
// cleared and needs no clearing pass, since only entries below the count are read.
`default_nettype none

`include "round_robin_run_queue_assert.svh"

module round_robin_run_queue #(
    parameter int unsigned QUEUE_DEPTH     = rrq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned THREAD_ID_WIDTH = rrq_pkg::THREAD_ID_WIDTH_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    rrq_req_if.sink   req,
    rrq_rsp_if.source rsp
);
    import rrq_pkg::*;

    localparam int unsigned ID_W  = THREAD_ID_WIDTH;
    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic [ID_W-1:0]  run_id_reg, run_id_next;
    logic             run_valid_reg, run_valid_next;
    op_t              op_reg, op_next;
    logic [ID_W-1:0]  pop_id_reg, pop_id_next;
    logic             pop_valid_reg, pop_valid_next;
    status_t          status_reg, status_next;
    logic [IDX_W-1:0] sh_reg, sh_next;

    logic             out_valid_reg, out_valid_next;
    logic [ID_W-1:0]  out_pop_id_reg, out_pop_id_next;
    logic             out_pop_valid_reg, out_pop_valid_next;
    logic [ID_W-1:0]  out_cur_id_reg, out_cur_id_next;
    logic             out_cur_valid_reg, out_cur_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;

    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [ID_W-1:0]  ram_wdata, ram_rdata;

    logic             in_fire, full;
    logic [CNT_W-1:0] next_pos;

    // Cursor moves back one, wrapping to the last entry of a queue of n.
    function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] c,
                                                   input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] c_ext;
        c_ext = CNT_W'(c);
        if (n == '0)
        begin
            return '0;
        end
        else if (c == '0 || c_ext >= n)
        begin
            return IDX_W'(n - CNT_W'(1));
        end
        else
        begin
            return c - IDX_W'(1);
        end
    endfunction

    rrq_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready         = (state_reg == ST_IDLE);
    assign in_fire           = req.valid && req.ready;
    assign full              = (count_reg == CNT_W'(QUEUE_DEPTH));

    assign rsp.valid          = out_valid_reg;
    assign rsp.popped_thread  = out_pop_id_reg;
    assign rsp.popped_valid   = out_pop_valid_reg;
    assign rsp.current_thread = out_cur_id_reg;
    assign rsp.current_valid  = out_cur_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.queue_count    = out_count_reg;

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        cursor_next        = cursor_reg;
        run_id_next        = run_id_reg;
        run_valid_next     = run_valid_reg;
        op_next            = op_reg;
        pop_id_next        = pop_id_reg;
        pop_valid_next     = pop_valid_reg;
        status_next        = status_reg;
        sh_next            = sh_reg;
        out_valid_next     = out_valid_reg;
        out_pop_id_next    = out_pop_id_reg;
        out_pop_valid_next = out_pop_valid_reg;
        out_cur_id_next    = out_cur_id_reg;
        out_cur_valid_next = out_cur_valid_reg;
        out_status_next    = out_status_reg;
        out_count_next     = out_count_reg;
        ram_we             = 1'b0;
        ram_waddr          = count_reg[IDX_W-1:0];
        ram_wdata          = req.thread_id;
        ram_re             = 1'b0;
        ram_raddr          = cursor_reg;
        next_pos           = CNT_W'(sh_reg) + CNT_W'(1);

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next        = req.op;
                    pop_id_next    = '0;
                    pop_valid_next = 1'b0;
                    status_next    = STATUS_OK;
                    state_next     = ST_DONE;
                    unique case (req.op)
                        OP_ENQUEUE:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_SWITCH:
                        begin
                            if (!(run_valid_reg && run_id_reg == req.thread_id))
                            begin
                                // current thread goes back to the tail
                                if (run_valid_reg)
                                begin
                                    if (full)
                                    begin
                                        status_next = STATUS_FULL;
                                    end
                                    else
                                    begin
                                        ram_we     = 1'b1;
                                        ram_wdata  = run_id_reg;
                                        count_next = count_reg + CNT_W'(1);
                                    end
                                end
                                if (req.target_terminated)
                                begin
                                    run_valid_next = 1'b0;
                                    run_id_next    = '0;
                                end
                                else
                                begin
                                    run_valid_next = 1'b1;
                                    run_id_next    = req.thread_id;
                                end
                            end
                        end
                        OP_YIELD, OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                next_pos = CNT_W'(cursor_reg) + CNT_W'(1);
                if (op_reg == OP_YIELD && run_valid_reg)
                begin
                    // swap the current thread with the entry under the cursor
                    ram_we      = 1'b1;
                    ram_waddr   = cursor_reg;
                    ram_wdata   = run_id_reg;
                    run_id_next = ram_rdata;
                    cursor_next = step_back(cursor_reg, count_reg);
                    state_next  = ST_DONE;
                end
                else
                begin
                    if (op_reg == OP_POP)
                    begin
                        pop_id_next    = ram_rdata;
                        pop_valid_next = 1'b1;
                    end
                    else
                    begin
                        run_id_next    = ram_rdata;
                        run_valid_next = 1'b1;
                    end
                    if (next_pos < count_reg)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = next_pos[IDX_W-1:0];
                        sh_next    = next_pos[IDX_W-1:0];
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        count_next  = count_reg - CNT_W'(1);
                        cursor_next = step_back(cursor_reg, count_reg - CNT_W'(1));
                        state_next  = ST_DONE;
                    end
                end
            end
            ST_SHIFT:
            begin
                // entry read last cycle moves down one slot; reads stay ahead of writes
                ram_we    = 1'b1;
                ram_waddr = sh_reg - IDX_W'(1);
                ram_wdata = ram_rdata;
                if (next_pos < count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = next_pos[IDX_W-1:0];
                    sh_next   = next_pos[IDX_W-1:0];
                end
                else
                begin
                    count_next  = count_reg - CNT_W'(1);
                    cursor_next = step_back(cursor_reg, count_reg - CNT_W'(1));
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next     = 1'b1;
                    out_pop_id_next    = pop_id_reg;
                    out_pop_valid_next = pop_valid_reg;
                    out_cur_id_next    = run_valid_reg ? run_id_reg : '0;
                    out_cur_valid_next = run_valid_reg;
                    out_status_next    = status_reg;
                    out_count_next     = count_reg;
                    state_next         = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            count_reg         <= '0;
            cursor_reg        <= '0;
            run_id_reg        <= '0;
            run_valid_reg     <= 1'b0;
            op_reg            <= OP_ENQUEUE;
            pop_id_reg        <= '0;
            pop_valid_reg     <= 1'b0;
            status_reg        <= STATUS_OK;
            sh_reg            <= '0;
            out_valid_reg     <= 1'b0;
            out_pop_id_reg    <= '0;
            out_pop_valid_reg <= 1'b0;
            out_cur_id_reg    <= '0;
            out_cur_valid_reg <= 1'b0;
            out_status_reg    <= STATUS_OK;
            out_count_reg     <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            count_reg         <= count_next;
            cursor_reg        <= cursor_next;
            run_id_reg        <= run_id_next;
            run_valid_reg     <= run_valid_next;
            op_reg            <= op_next;
            pop_id_reg        <= pop_id_next;
            pop_valid_reg     <= pop_valid_next;
            status_reg        <= status_next;
            sh_reg            <= sh_next;
            out_valid_reg     <= out_valid_next;
            out_pop_id_reg    <= out_pop_id_next;
            out_pop_valid_reg <= out_pop_valid_next;
            out_cur_id_reg    <= out_cur_id_next;
            out_cur_valid_reg <= out_cur_valid_next;
            out_status_reg    <= out_status_next;
            out_count_reg     <= out_count_next;
        end
    end

    `RRQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
    `RRQ_ASSERT_NOW(a_cursor_in_queue, clk, rst_n, state_reg == ST_IDLE, (count_reg == '0 && cursor_reg == '0) || CNT_W'(cursor_reg) < count_reg, "cursor outside the queue")
    `RRQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, state_reg != ST_IDLE, "request accepted but block stayed idle")
    `RRQ_ASSERT_NOW(a_pop_only_on_pop, clk, rst_n, pop_valid_reg && state_reg == ST_DONE, op_reg == OP_POP && status_reg == STATUS_OK, "popped thread on a non-pop request")
endmodule

`default_nettype wire

// ===== tb/round_robin_run_queue_test.sv =====
// Self-checking testbench for the round-robin run queue: directed and random requests.
`default_nettype none

module round_robin_run_queue_test;
    import rrq_pkg::*;

    localparam int unsigned DEPTH     = QUEUE_DEPTH_DEF;
    localparam int unsigned RAND_REQS = 1850;
    localparam int unsigned TAIL_WAIT = 80;

    typedef struct packed {
        logic [15:0] popped_thread;
        logic        popped_valid;
        logic [15:0] current_thread;
        logic        current_valid;
        status_t     status;
        logic [6:0]  queue_count;
    } outcome_t;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } mix_mode_t;

    // Tracks the queue and the running thread, and checks each result in order.
    class run_queue_shadow;
        logic [15:0] slots[DEPTH];
        int unsigned count;
        int unsigned cursor;
        logic [15:0] cur_thread;
        logic        cur_valid;
        outcome_t    pending_outcomes[$];
        int unsigned errors;

        function new();
            count      = 0;
            cursor     = 0;
            cur_thread = '0;
            cur_valid  = 1'b0;
            errors     = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 60)
                $display("mismatch: %s", msg);
        endtask

        function bit push_tail(logic [15:0] id);
            if (count >= DEPTH)
                return 1'b0;
            slots[count] = id;
            count++;
            return 1'b1;
        endfunction

        function void step_back();
            if (count == 0)
                cursor = 0;
            else if (cursor == 0 || cursor >= count)
                cursor = count - 1;
            else
                cursor--;
        endfunction

        function logic [15:0] take_at_cursor();
            logic [15:0] out;
            if (cursor >= count)
                cursor = 0;
            out = slots[cursor];
            for (int unsigned i = cursor + 1; i < count; i++)
                slots[i-1] = slots[i];
            count--;
            step_back();
            return out;
        endfunction

        function void note_request(op_t op, logic [15:0] id, logic term);
            outcome_t    o;
            logic [15:0] tmp;
            int unsigned idx;
            o = '0;
            o.status = STATUS_OK;
            case (op)
                OP_ENQUEUE:
                    if (!push_tail(id))
                        o.status = STATUS_FULL;
                OP_YIELD:
                    if (count == 0) begin
                        o.status = STATUS_EMPTY;
                    end
                    else if (!cur_valid) begin
                        cur_thread = take_at_cursor();
                        cur_valid  = 1'b1;
                    end
                    else begin
                        idx = (cursor < count) ? cursor : 0;
                        tmp = slots[idx];
                        slots[idx] = cur_thread;
                        cur_thread = tmp;
                        cursor = idx;
                        step_back();
                    end
                OP_POP:
                    if (count == 0) begin
                        o.status = STATUS_EMPTY;
                    end
                    else begin
                        o.popped_thread = take_at_cursor();
                        o.popped_valid  = 1'b1;
                    end
                default:
                    // switching to the running thread is a no-op
                    if (!(cur_valid && cur_thread == id)) begin
                        if (cur_valid && !push_tail(cur_thread))
                            o.status = STATUS_FULL;
                        if (term) begin
                            cur_valid  = 1'b0;
                            cur_thread = '0;
                        end
                        else begin
                            cur_thread = id;
                            cur_valid  = 1'b1;
                        end
                    end
            endcase
            o.current_thread = cur_valid ? cur_thread : 16'h0;
            o.current_valid  = cur_valid;
            o.queue_count    = 7'(count);
            pending_outcomes.push_back(o);
        endfunction

        task check_outcome(outcome_t got);
            outcome_t exp;
            if (pending_outcomes.size() == 0) begin
                report($sformatf("unexpected result pop=%h/%b cur=%h/%b st=%0d cnt=%0d",
                                 got.popped_thread, got.popped_valid, got.current_thread,
                                 got.current_valid, got.status, got.queue_count));
            end
            else begin
                exp = pending_outcomes.pop_front();
                if (got !== exp)
                    report($sformatf({"pop=%h/%b cur=%h/%b st=%0d cnt=%0d, ",
                                      "want pop=%h/%b cur=%h/%b st=%0d cnt=%0d"},
                                     got.popped_thread, got.popped_valid,
                                     got.current_thread, got.current_valid,
                                     got.status, got.queue_count,
                                     exp.popped_thread, exp.popped_valid,
                                     exp.current_thread, exp.current_valid,
                                     exp.status, exp.queue_count));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   calm;

    rrq_req_if #(.ID_W(16)) req_ch ();
    rrq_rsp_if              rsp_ch ();

    round_robin_run_queue u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    run_queue_shadow shadow = new();

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic send_request(op_t op, logic [15:0] id, logic term);
        int unsigned gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid             <= 1'b1;
        req_ch.op                <= op;
        req_ch.thread_id         <= id;
        req_ch.target_terminated <= term;
        forever
        begin
            @(posedge clk);
            if (req_ch.ready === 1'b1)
                break;
        end
        shadow.note_request(op, id, term);
        @(negedge clk);
    endtask

    function automatic op_t pick_op(mix_mode_t mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                return (r < 70) ? OP_ENQUEUE : (r < 82) ? OP_SWITCH :
                       (r < 92) ? OP_YIELD : OP_POP;
            MODE_DRAIN:
                return (r < 10) ? OP_ENQUEUE : (r < 20) ? OP_SWITCH :
                       (r < 55) ? OP_YIELD : OP_POP;
            default:
                return op_t'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [15:0] pick_id(op_t op);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (op == OP_SWITCH && shadow.cur_valid && r < 5)
            return shadow.cur_thread;
        if (r < 6)
            return 16'h0000;
        if (r < 8)
            return 16'hFFFF;
        if (r < 12)
            return 16'($urandom_range(0, 15));
        return 16'($urandom);
    endfunction

    // result side: ready drops for random stretches
    initial
    begin
        int unsigned stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            shadow.check_outcome('{popped_thread:  rsp_ch.popped_thread,
                                   popped_valid:   rsp_ch.popped_valid,
                                   current_thread: rsp_ch.current_thread,
                                   current_valid:  rsp_ch.current_valid,
                                   status:         rsp_ch.status,
                                   queue_count:    rsp_ch.queue_count});
    end

    initial
    begin
        int unsigned sent;
        int unsigned phase_len;
        mix_mode_t   mode;
        op_t         op;
        logic        term;

        calm                     = 1'b0;
        rst_n                    = 1'b0;
        req_ch.valid             = 1'b0;
        req_ch.op                = OP_ENQUEUE;
        req_ch.thread_id         = '0;
        req_ch.target_terminated = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty queue, terminated target, no current thread, swaps
        send_request(OP_POP,     16'h0000, 1'b0);
        send_request(OP_YIELD,   16'h0000, 1'b0);
        send_request(OP_SWITCH,  16'h1234, 1'b1);
        send_request(OP_SWITCH,  16'h0000, 1'b0);
        send_request(OP_SWITCH,  16'h0000, 1'b0);
        send_request(OP_ENQUEUE, 16'hFFFF, 1'b0);
        send_request(OP_ENQUEUE, 16'h0000, 1'b1);
        send_request(OP_ENQUEUE, 16'hA5A5, 1'b0);
        send_request(OP_YIELD,   16'h0000, 1'b0);
        send_request(OP_SWITCH,  16'h5A5A, 1'b0);
        send_request(OP_SWITCH,  16'h7777, 1'b1);
        send_request(OP_YIELD,   16'hFFFF, 1'b1);
        send_request(OP_SWITCH,  shadow.cur_thread, 1'b1);
        send_request(OP_POP,     16'h0000, 1'b0);
        send_request(OP_POP,     16'h0000, 1'b0);
        send_request(OP_YIELD,   16'h0000, 1'b0);
        repeat (5) send_request(OP_POP, 16'h0000, 1'b0);
        send_request(OP_ENQUEUE, 16'h8000, 1'b0);
        send_request(OP_ENQUEUE, 16'h0001, 1'b0);
        send_request(OP_SWITCH,  16'h4321, 1'b0);
        send_request(OP_YIELD,   16'h0000, 1'b0);

        // random: phases that fill to overflow, drain to empty, or mix
        sent = 0;
        while (sent < RAND_REQS)
        begin
            mode      = mix_mode_t'($urandom_range(0, 2));
            phase_len = (mode == MODE_FILL) ? $urandom_range(100, 250)
                                            : $urandom_range(40, 150);
            calm      = ($urandom_range(0, 3) == 0);
            for (int unsigned k = 0; k < phase_len && sent < RAND_REQS; k++)
            begin
                op   = pick_op(mode);
                term = (op == OP_SWITCH) ? ($urandom_range(0, 3) == 0) : 1'($urandom);
                send_request(op, pick_id(op), term);
                sent++;
            end
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        while (shadow.pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (shadow.errors == 0)
            $display("[round_robin_run_queue] OK");
        else
            $display("[round_robin_run_queue] ERROR");
        $finish;
    end

    initial
    begin
        #16_000_000;
        $display("timeout");
        $display("[round_robin_run_queue] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/rrq_pkg.sv
sv/rrq_req_if.sv
sv/rrq_rsp_if.sv
sv/rrq_ram.sv
sv/round_robin_run_queue.sv
tb/round_robin_run_queue_test.sv
